// ----- rtl/bda_pkg.sv -----
// Package with the types, constants and conversion steps of the decimal ASCII converter.
`default_nettype none
package bda_pkg;

   localparam int unsigned NUM_WIDTH    = 32;
   localparam int unsigned DIGIT_COUNT  = 10;
   localparam int unsigned BCD_WIDTH    = 4 * DIGIT_COUNT;
   localparam int unsigned STEPS_PER_ST = 4;
   localparam int unsigned STAGE_COUNT  = NUM_WIDTH / STEPS_PER_ST;
   localparam int unsigned CHAR_WIDTH   = 6;
   localparam int unsigned IDX_WIDTH    = 4;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 6'd48;
   localparam logic [CHAR_WIDTH-1:0] ASCII_NINE = 6'd57;

   typedef logic [BCD_WIDTH-1:0] bcd_type;
   typedef logic [NUM_WIDTH-1:0] num_type;
   typedef logic [IDX_WIDTH-1:0] idx_type;

   // One shift-and-add-3 step: correct every digit of five or more, then shift in a bit.
   function automatic bcd_type dabble_step(input bcd_type acc, input logic bit_in);
      bcd_type fixed;
      fixed = acc;
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         if (fixed[4*d +: 4] >= 4'd5) begin
            fixed[4*d +: 4] = fixed[4*d +: 4] + 4'd3;
         end
      end
      return {fixed[BCD_WIDTH-2:0], bit_in};
   endfunction

   // The steps of one pipeline stage, taking the top bits of the value first.
   function automatic bcd_type stage_steps(input bcd_type acc, input num_type value);
      bcd_type work;
      work = acc;
      for (int s = 0; s < STEPS_PER_ST; s++) begin
         work = dabble_step(work, value[NUM_WIDTH-1-s]);
      end
      return work;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/binary_to_decimal_ascii.sv -----
// Top level: pipelined 32-bit binary to decimal ASCII converter with a digit emitter.
`default_nettype none
// Each request carries a 32-bit unsigned number; the block answers with its decimal digits
// as ASCII characters, most significant first, without leading zeros, and marks the least
// significant digit with rsp_tlast (zero gives a single '0'). The conversion runs through an
// eight-stage shift-and-add-3 pipeline, four bit steps per stage, that accepts a number in
// every cycle unless backpressure from the emitter stalls it; rsp_tvalid rises once the number
// has passed all stages and been loaded into the emitter registers. The digit emitter sends one
// character per cycle while rsp_tready is high, and a number has from 1 to 10 digits;
// that emitter sets the sustained rate.
module binary_to_decimal_ascii
   import bda_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] number
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,    // [5:0] digit_char, [7:6] zero
   output logic            rsp_tlast     // last_digit
);

   // Pipeline stage registers.
   logic    st_valid_ff [STAGE_COUNT];
   bcd_type st_acc_ff   [STAGE_COUNT];
   num_type st_val_ff   [STAGE_COUNT];
   logic    st_ready    [STAGE_COUNT];

   // Emitter registers.
   logic    em_valid_ff, em_valid_in;
   bcd_type em_bcd_ff,   em_bcd_in;
   idx_type em_idx_ff,   em_idx_in;
   logic    em_load;
   idx_type top_idx;
   logic [3:0] cur_nib;
   logic    rsp_take;

   assign rsp_take = rsp_tvalid && rsp_tready;
   assign em_load  = st_valid_ff[STAGE_COUNT-1] &&
                     (!em_valid_ff || (rsp_take && em_idx_ff == '0));

   // Backpressure chain: a stage may take new data when empty or when it moves on.
   always_comb begin
      st_ready[STAGE_COUNT-1] = !st_valid_ff[STAGE_COUNT-1] || em_load;
      for (int k = STAGE_COUNT - 2; k >= 0; k--) begin
         st_ready[k] = !st_valid_ff[k] || st_ready[k+1];
      end
   end
   assign req_tready = st_ready[0];

   // Conversion stages, each doing four bit steps.
   for (genvar k = 0; k < STAGE_COUNT; k++) begin : g_stage
      logic    src_valid;
      bcd_type src_acc;
      num_type src_val;
      if (k == 0) begin : g_first
         assign src_valid = req_tvalid;
         assign src_acc   = '0;
         assign src_val   = req_tdata;
      end else begin : g_rest
         assign src_valid = st_valid_ff[k-1];
         assign src_acc   = st_acc_ff[k-1];
         assign src_val   = st_val_ff[k-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            st_valid_ff[k] <= 1'b0;
         end else if (st_ready[k]) begin
            st_valid_ff[k] <= src_valid;
         end
         if (st_ready[k] && src_valid) begin
            st_acc_ff[k] <= stage_steps(src_acc, src_val);
            st_val_ff[k] <= src_val << STEPS_PER_ST;
         end
      end
   end

   // Most significant nonzero digit of the finished conversion; zero gives digit 0.
   always_comb begin
      top_idx = '0;
      for (int d = 1; d < DIGIT_COUNT; d++) begin
         if (st_acc_ff[STAGE_COUNT-1][4*d +: 4] != 4'd0) begin
            top_idx = IDX_WIDTH'(d);
         end
      end
   end

   // Emitter: load a number, then step down one digit per taken character.
   always_comb begin
      em_valid_in = em_valid_ff;
      em_bcd_in   = em_bcd_ff;
      em_idx_in   = em_idx_ff;
      if (em_load) begin
         em_valid_in = 1'b1;
         em_bcd_in   = st_acc_ff[STAGE_COUNT-1];
         em_idx_in   = top_idx;
      end else if (rsp_take) begin
         if (em_idx_ff == '0) begin
            em_valid_in = 1'b0;
         end else begin
            em_idx_in = em_idx_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff <= 1'b0;
      end else begin
         em_valid_ff <= em_valid_in;
      end
      em_bcd_ff <= em_bcd_in;
      em_idx_ff <= em_idx_in;
   end

   // Current digit select.
   always_comb begin
      cur_nib = 4'd0;
      for (int d = 0; d < DIGIT_COUNT; d++) begin
         if (em_idx_ff == IDX_WIDTH'(d)) begin
            cur_nib = em_bcd_ff[4*d +: 4];
         end
      end
   end

   assign rsp_tvalid = em_valid_ff;
   assign rsp_tdata  = {2'b00, ASCII_ZERO + {2'b00, cur_nib}};
   assign rsp_tlast  = (em_idx_ff == '0);

   // Every character sent is a decimal digit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5:0] >= ASCII_ZERO && rsp_tdata[5:0] <= ASCII_NINE))
      else $error("character outside the decimal digits");

   // A freshly loaded run never starts with a leading zero unless it is the only digit.
   assert property (@(posedge clock) disable iff (reset)
      em_load |=> (em_idx_ff == '0 || cur_nib != 4'd0))
      else $error("leading zero emitted");

   // A stalled final stage keeps its conversion.
   assert property (@(posedge clock) disable iff (reset)
      (st_valid_ff[STAGE_COUNT-1] && !em_load) |=>
         (st_valid_ff[STAGE_COUNT-1] && $stable(st_acc_ff[STAGE_COUNT-1])))
      else $error("stalled conversion lost");

endmodule
`default_nettype wire
